// File: hw/rtl/utf8_codepoint_validator_unit_assert.svh
// Assertion macros for the UTF-8 codepoint validator
`ifndef UTF8_CODEPOINT_VALIDATOR_UNIT_ASSERT_SVH
`define UTF8_CODEPOINT_VALIDATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, ignored while reset is held
`define UCV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("utf8cv assertion failed");
// Next-cycle implication, ignored while reset is held
`define UCV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("utf8cv assertion failed");
`else
`define UCV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UCV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/utf8cv_pkg.sv
`default_nettype none

package utf8cv_pkg;

  // Status codes of one result item
  typedef enum logic [2:0] {
    ST_PENDING   = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_BAD_LEAD  = 3'd2,
    ST_BAD_CONT  = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  // Byte values that steer decoding
  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [7:0] BYTE_CR        = 8'h0D;
  localparam logic [7:0] ASCII_MAX      = 8'h7F;
  localparam logic [7:0] LEAD2_MIN      = 8'hC2;
  localparam logic [7:0] LEAD2_MAX      = 8'hDF;
  localparam logic [7:0] LEAD3_E0       = 8'hE0;
  localparam logic [7:0] LEAD3_ED       = 8'hED;
  localparam logic [7:0] LEAD3_MAX      = 8'hEF;
  localparam logic [7:0] LEAD4_F0       = 8'hF0;
  localparam logic [7:0] LEAD4_F4       = 8'hF4;
  localparam logic [7:0] CONT_MIN       = 8'h80;
  localparam logic [7:0] CONT_MAX       = 8'hBF;
  localparam logic [7:0] CONT_E0_MIN    = 8'hA0;
  localparam logic [7:0] CONT_ED_MAX    = 8'h9F;
  localparam logic [7:0] CONT_F0_MIN    = 8'h90;
  localparam logic [7:0] CONT_F4_MAX    = 8'h8F;

  localparam logic [2:0] LEN_ONE        = 3'd1;
  localparam logic [2:0] LEN_TWO        = 3'd2;
  localparam logic [2:0] LEN_THREE      = 3'd3;
  localparam logic [2:0] LEN_FOUR       = 3'd4;

  // One text byte as carried through the input register
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // Sequence tracking state
  typedef struct packed {
    logic [1:0] remaining;
    logic [2:0] length;
    logic [7:0] low_bound;
    logic [7:0] high_bound;
  } seq_state_t;

  localparam seq_state_t SEQ_IDLE = '{
    remaining:  2'd0,
    length:     3'd0,
    low_bound:  CONT_MIN,
    high_bound: CONT_MAX
  };

  // Build the state that opens a multi-byte sequence
  function automatic seq_state_t seq_start(input logic [2:0] len,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    seq_state_t s;
    s.remaining  = 2'(len - 3'd1);
    s.length     = len;
    s.low_bound  = lo;
    s.high_bound = hi;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/utf8cv_in_stage.sv
`default_nettype none

module utf8cv_in_stage
  import utf8cv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     advance,
  output logic          s1_valid,
  output in_item_t      s1_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     load;

  // Load when the register is empty or its item moves on this cycle
  assign load     = !valid_r || advance;
  assign in_stall = !load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = in_valid;
    end
  end

  // Hold the item until the decode stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

`default_nettype wire

// File: hw/rtl/utf8cv_step.sv
`default_nettype none

module utf8cv_step
  import utf8cv_pkg::*;
(
  input  wire seq_state_t state,
  input  wire in_item_t   item,
  input  wire logic       reject_line_breaks,
  output status_t         status,
  output logic [2:0]      codepoint_length,
  output seq_state_t      state_nxt
);

  logic [7:0] b;
  logic [1:0] rem_dec;

  assign b       = item.text_byte;
  assign rem_dec = state.remaining - 2'd1;

  // Decode one byte against the current sequence state
  always_comb begin
    status           = ST_PENDING;
    codepoint_length = 3'd0;
    state_nxt        = state;
    if (state.remaining == 2'd0) begin
      // Lead byte
      priority if (reject_line_breaks && (b == BYTE_LF || b == BYTE_CR)) begin
        status = ST_BAD_LEAD;
      end else if (b <= ASCII_MAX) begin
        status           = ST_COMPLETE;
        codepoint_length = LEN_ONE;
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        state_nxt = seq_start(LEN_TWO, CONT_MIN, CONT_MAX);
      end else if (b == LEAD3_E0) begin
        state_nxt = seq_start(LEN_THREE, CONT_E0_MIN, CONT_MAX);
      end else if (b == LEAD3_ED) begin
        state_nxt = seq_start(LEN_THREE, CONT_MIN, CONT_ED_MAX);
      end else if (b > LEAD3_E0 && b <= LEAD3_MAX) begin
        state_nxt = seq_start(LEN_THREE, CONT_MIN, CONT_MAX);
      end else if (b == LEAD4_F0) begin
        state_nxt = seq_start(LEN_FOUR, CONT_F0_MIN, CONT_MAX);
      end else if (b == LEAD4_F4) begin
        state_nxt = seq_start(LEN_FOUR, CONT_MIN, CONT_F4_MAX);
      end else if (b > LEAD4_F0 && b < LEAD4_F4) begin
        state_nxt = seq_start(LEN_FOUR, CONT_MIN, CONT_MAX);
      end else begin
        status = ST_BAD_LEAD;
      end
      // A sequence opened on the last byte is cut short
      if (status == ST_PENDING && item.end_of_text) begin
        status    = ST_TRUNCATED;
        state_nxt = SEQ_IDLE;
      end
    end else if (b >= state.low_bound && b <= state.high_bound) begin
      // Continuation byte in range
      state_nxt.remaining  = rem_dec;
      state_nxt.low_bound  = CONT_MIN;
      state_nxt.high_bound = CONT_MAX;
      if (rem_dec == 2'd0) begin
        status           = ST_COMPLETE;
        codepoint_length = state.length;
        state_nxt        = SEQ_IDLE;
      end else if (item.end_of_text) begin
        status    = ST_TRUNCATED;
        state_nxt = SEQ_IDLE;
      end
    end else begin
      // Drop the offending byte and start fresh
      status    = ST_BAD_CONT;
      state_nxt = SEQ_IDLE;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/utf8_codepoint_validator_unit.sv
// UTF-8 codepoint validator.
// Input channel: in_valid / in_stall with in_text_byte and in_end_of_text,
// one text byte per item. Result channel: out_valid / out_stall with
// out_status (pending, complete, bad lead, bad continuation, truncated)
// and out_codepoint_length (non-zero only when a codepoint completes).
// Every byte yields exactly one result item, in order.
// Configuration: cfg_write_enable / cfg_write_data set the line-break
// rejection flag; write it only while no items are in flight.
// Each byte passes through the input register, then the result register.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the single decode step between the two registers; the sequence state
// updates as each result is registered.
// Reset (rst_n low, synchronous): both registers empty, sequence state idle,
// line-break rejection on.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more byte if it is empty; beyond that in_stall rises.
`default_nettype none
`include "utf8_codepoint_validator_unit_assert.svh"

module utf8_codepoint_validator_unit
  import utf8cv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_write_enable,
  input  wire logic       cfg_write_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic [2:0]      out_codepoint_length
);

  in_item_t   in_item;
  in_item_t   s1_item;
  logic       s1_valid;
  logic       advance;
  logic       take;

  logic       reject_lb_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  status_t    step_status;
  logic [2:0] step_length;

  logic       out_valid_r;
  logic       out_valid_nxt;
  status_t    status_r;
  logic [2:0] length_r;

  assign in_item.text_byte   = in_text_byte;
  assign in_item.end_of_text = in_end_of_text;

  // Move on whenever the result register is free or being drained
  assign advance = !out_valid_r || !out_stall;
  assign take    = s1_valid && advance;

  utf8cv_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  utf8cv_step u_step (
    .state              (state_r),
    .item               (s1_item),
    .reject_line_breaks (reject_lb_r),
    .status             (step_status),
    .codepoint_length   (step_length),
    .state_nxt          (state_nxt)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reject_lb_r <= 1'b1;
    end else if (cfg_write_enable) begin
      reject_lb_r <= cfg_write_data;
    end
  end

  // Advance the sequence state as each item is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else if (take) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= step_status;
      length_r <= step_length;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_codepoint_length = length_r;

  // Checks
  `UCV_ASSERT_IMP(a_len_only_on_complete, clk, rst_n, out_valid_r && status_r != ST_COMPLETE, length_r == 3'd0)
  `UCV_ASSERT_IMP(a_complete_len_range, clk, rst_n, out_valid_r && status_r == ST_COMPLETE, length_r >= LEN_ONE && length_r <= LEN_FOUR)
  `UCV_ASSERT_IMP(a_idle_state_clean, clk, rst_n, state_r.remaining == 2'd0, state_r == SEQ_IDLE)
  `UCV_ASSERT_IMP(a_length_covers_rem, clk, rst_n, state_r.remaining != 2'd0, 3'(state_r.remaining) < state_r.length)
  `UCV_ASSERT_NXT(a_bad_cont_to_idle, clk, rst_n, take && step_status == ST_BAD_CONT, state_r.remaining == 2'd0)

endmodule

`default_nettype wire
